[design/sbpa_pkg.sv]
// Package for the stereo bandpass bank power meter with automatic gain.
// Holds request, result, coefficient and register types, codes and reset values.
// No dependencies.
package sbpa_pkg;

    localparam int DEF_BANKS = 64;

    localparam logic [31:0] GAIN_FLOOR_RESET = 32'd21474836;
    localparam logic [31:0] INC_RATE_RESET   = 32'd9739155;
    localparam logic [31:0] DEC_RATE_RESET   = 32'd32464;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_READOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_GAIN_FLOOR = 2'd0,
        CFG_INC_RATE   = 2'd1,
        CFG_DEC_RATE   = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_DRAIN,
        ST_READOUT
    } t_state;

    typedef enum logic [2:0] {
        RO_IDLE,
        RO_READ,
        RO_DATA,
        RO_ROOT_GO,
        RO_ROOT,
        RO_GAIN_F,
        RO_GAIN_P,
        RO_GAIN_A
    } t_ro_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         bank_index;
        logic signed [31:0] coef_fb1;
        logic signed [31:0] coef_fb2;
        logic signed [31:0] coef_gain;
        logic signed [31:0] coef_smooth;
        logic signed [23:0] sample_left;
        logic signed [23:0] sample_right;
    } t_request;

    typedef struct packed {
        logic [5:0]  bank_number;
        logic [31:0] power_left;
        logic [31:0] power_right;
        logic [31:0] gain_left_out;
        logic [31:0] gain_right_out;
        logic [31:0] peak_left;
        logic [31:0] peak_right;
        logic        last;
    } t_result;

    typedef struct packed {
        logic signed [31:0] fb1;
        logic signed [31:0] fb2;
        logic signed [31:0] gain;
        logic signed [31:0] smooth;
    } t_coef;

    typedef struct packed {
        logic [31:0] gain_floor;
        logic [31:0] inc_rate;
        logic [31:0] dec_rate;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [15:0] count;
    } t_ro_ctrl;

endpackage

[design/sbpa_isqrt.sv]
// Iterative integer square root of a 32-bit value shifted up by 32 bits.
// One result bit per cycle. Depends on nothing.
module sbpa_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        fits;

    assign rem_sh = {r_rem[31:0], r_rad[63:62]};
    assign trial  = {r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {i_value, 32'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (fits) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[design/sbpa_lane.sv]
// One channel lane: biquad bandpass and smoothed power for every bank, one bank per cycle.
// Holds the filter histories and powers of its channel. Depends on sbpa_pkg.
module sbpa_lane
    import sbpa_pkg::*;
#(
    parameter int BANKS = DEF_BANKS,
    parameter int BW    = (BANKS > 1) ? $clog2(BANKS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_issue,
    input  logic [BW-1:0]      i_bank,
    input  logic signed [23:0] i_x,
    input  t_coef              i_coef,
    input  logic [BW-1:0]      i_ro_addr,
    output logic [31:0]        o_power,
    output logic               o_busy
);

    logic [47:0] r_in_hist  [BANKS];
    logic [63:0] r_out_hist [BANKS];
    logic [31:0] r_pow      [BANKS];
    logic [BANKS-1:0] r_vld;

    logic [BW-1:0] rd_addr;
    logic [47:0]   r_in_rd;
    logic [63:0]   r_out_rd;
    logic [31:0]   r_pow_rd;
    logic          r_vld_rd;

    logic          r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic [BW-1:0] r_s1_bank, r_s2_bank, r_s3_bank, r_s4_bank, r_s5_bank, r_s6_bank;

    logic [47:0]        in_h;
    logic [63:0]        out_h;
    logic [31:0]        pow_h;
    logic signed [23:0] s1_x2;
    logic signed [31:0] s1_y1, s1_y2;
    logic signed [24:0] s1_d;
    logic signed [56:0] s1_pg;
    logic signed [63:0] s1_pf1, s1_pf2;

    logic signed [56:0] r_s2_pg;
    logic signed [63:0] r_s2_pf1, r_s2_pf2;
    logic [23:0]        r_s2_x, r_s2_x1;
    logic [31:0]        r_s2_y1;
    logic [31:0]        r_s2_p, r_s3_p, r_s4_p, r_s5_p, r_s6_p;
    logic signed [31:0] r_s2_sm, r_s3_sm, r_s4_sm, r_s5_sm;

    logic signed [65:0] s2_acc, s2_rnd;
    logic signed [37:0] s2_y38;
    logic signed [31:0] s2_y;
    logic signed [31:0] r_s3_y;

    logic signed [63:0] s3_yy;
    logic [63:0]        r_s4_yy;

    logic [63:0]        s4_sum;
    logic [34:0]        s4_t;
    logic [31:0]        s4_sq;
    logic signed [33:0] s4_d;
    logic signed [33:0] r_s5_d;

    logic signed [65:0] s5_prod;
    logic signed [65:0] r_s6_prod;

    logic signed [65:0] s6_rnd;
    logic signed [37:0] s6_np;
    logic [31:0]        s6_pow;

    assign rd_addr = i_issue ? i_bank : i_ro_addr;

    always_ff @(posedge i_clk) begin
        r_in_rd  <= r_in_hist[rd_addr];
        r_out_rd <= r_out_hist[rd_addr];
        r_pow_rd <= r_pow[rd_addr];
        r_vld_rd <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_s1_v <= i_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            if (r_s6_v) begin
                r_vld[r_s6_bank] <= 1'b1;
            end
        end
    end

    assign in_h  = r_vld_rd ? r_in_rd : '0;
    assign out_h = r_vld_rd ? r_out_rd : '0;
    assign pow_h = r_vld_rd ? r_pow_rd : '0;

    assign s1_x2  = in_h[47:24];
    assign s1_y1  = out_h[31:0];
    assign s1_y2  = out_h[63:32];
    assign s1_d   = {i_x[23], i_x} - {s1_x2[23], s1_x2};
    assign s1_pg  = i_coef.gain * s1_d;
    assign s1_pf1 = i_coef.fb1 * s1_y1;
    assign s1_pf2 = i_coef.fb2 * s1_y2;

    always_ff @(posedge i_clk) begin
        r_s1_bank <= i_bank;
        r_s2_bank <= r_s1_bank;
        r_s3_bank <= r_s2_bank;
        r_s4_bank <= r_s3_bank;
        r_s5_bank <= r_s4_bank;
        r_s6_bank <= r_s5_bank;
        r_s2_pg   <= s1_pg;
        r_s2_pf1  <= s1_pf1;
        r_s2_pf2  <= s1_pf2;
        r_s2_x    <= i_x;
        r_s2_x1   <= in_h[23:0];
        r_s2_y1   <= out_h[31:0];
        r_s2_p    <= pow_h;
        r_s2_sm   <= i_coef.smooth;
        r_s3_y    <= s2_y;
        r_s3_p    <= r_s2_p;
        r_s3_sm   <= r_s2_sm;
        r_s4_yy   <= s3_yy;
        r_s4_p    <= r_s3_p;
        r_s4_sm   <= r_s3_sm;
        r_s5_d    <= s4_d;
        r_s5_p    <= r_s4_p;
        r_s5_sm   <= r_s4_sm;
        r_s6_prod <= s5_prod;
        r_s6_p    <= r_s5_p;
    end

    assign s2_acc = {{3{r_s2_pg[56]}}, r_s2_pg, 6'd0}
                  + {{3{r_s2_pf1[63]}}, r_s2_pf1[63:1]}
                  + {{3{r_s2_pf2[63]}}, r_s2_pf2[63:1]};
    assign s2_rnd = s2_acc + 66'sd134217728;
    assign s2_y38 = s2_rnd[65:28];

    always_comb begin
        if ((s2_y38[37:31] == 7'h00) || (s2_y38[37:31] == 7'h7F)) begin
            s2_y = s2_y38[31:0];
        end else if (s2_y38[37]) begin
            s2_y = 32'sh80000000;
        end else begin
            s2_y = 32'sh7FFFFFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_in_hist[r_s2_bank]  <= {r_s2_x1, r_s2_x};
            r_out_hist[r_s2_bank] <= {r_s2_y1, s2_y};
        end
    end

    assign s3_yy  = r_s3_y * r_s3_y;

    assign s4_sum = r_s4_yy + 64'd268435456;
    assign s4_t   = s4_sum[63:29];
    assign s4_sq  = (s4_t[34:32] != 3'd0) ? 32'hFFFFFFFF : s4_t[31:0];
    assign s4_d   = $signed({2'b00, s4_sq}) - $signed({2'b00, r_s4_p});

    assign s5_prod = r_s5_sm * r_s5_d;

    assign s6_rnd = r_s6_prod + 66'sd268435456;
    assign s6_np  = $signed({6'd0, r_s6_p}) + {s6_rnd[65], s6_rnd[65:29]};

    always_comb begin
        if (s6_np[37]) begin
            s6_pow = '0;
        end else if (s6_np[36:32] != 5'd0) begin
            s6_pow = 32'hFFFFFFFF;
        end else begin
            s6_pow = s6_np[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s6_v) begin
            r_pow[r_s6_bank] <= s6_pow;
        end
    end

    assign o_power = pow_h;
    assign o_busy  = r_s1_v | r_s2_v | r_s3_v | r_s4_v | r_s5_v | r_s6_v;

endmodule

[design/sbpa_merge.sv]
// Readout stage: sends each bank's powers, tracks the peak, takes its root and updates the gains.
// Uses two sbpa_isqrt units. Depends on sbpa_pkg.
module sbpa_merge
    import sbpa_pkg::*;
#(
    parameter int BANKS = DEF_BANKS,
    parameter int BW    = (BANKS > 1) ? $clog2(BANKS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ro_ctrl      i_ctrl,
    input  t_cfg          i_cfg,
    input  logic [31:0]   i_pow_l,
    input  logic [31:0]   i_pow_r,
    output logic [BW-1:0] o_addr,
    output logic          o_done,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_result       o_out_res
);

    t_ro_state r_state, n_state;

    logic [BW-1:0] r_addr, n_addr;
    logic [31:0]   r_max_l, n_max_l, r_max_r, n_max_r;
    logic [31:0]   r_hold_l, n_hold_l, r_hold_r, n_hold_r;
    logic [31:0]   r_raw_l, n_raw_l, r_raw_r, n_raw_r;
    logic [47:0]   r_f_l, n_f_l, r_f_r, n_f_r;
    logic          r_up_l, n_up_l, r_up_r, n_up_r;
    logic [64:0]   r_prod_l, n_prod_l, r_prod_r, n_prod_r;
    logic [31:0]   r_gain_l, n_gain_l, r_gain_r, n_gain_r;
    logic          r_ovalid, n_ovalid;
    t_result       r_out, n_out;

    logic        sq_start;
    logic        done_l, done_r;
    logic [31:0] root_l, root_r;
    logic        out_free;
    logic [32:0] fs_l, fs_r;
    logic [31:0] diff_l, diff_r;
    logic [31:0] g_l, g_r;

    sbpa_isqrt u_sqrt_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_max_l),
        .o_done  (done_l),
        .o_root  (root_l)
    );

    sbpa_isqrt u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_max_r),
        .o_done  (done_r),
        .o_root  (root_r)
    );

    assign out_free = !r_ovalid || !i_out_stall;

    assign fs_l   = (r_f_l > 48'h100000000) ? 33'h100000000 : r_f_l[32:0];
    assign fs_r   = (r_f_r > 48'h100000000) ? 33'h100000000 : r_f_r[32:0];
    assign diff_l = r_up_l ? (r_raw_l - r_gain_l) : (r_gain_l - r_raw_l);
    assign diff_r = r_up_r ? (r_raw_r - r_gain_r) : (r_gain_r - r_raw_r);

    always_comb begin
        g_l = r_up_l ? (r_gain_l + r_prod_l[63:32]) : (r_gain_l - r_prod_l[63:32]);
        g_r = r_up_r ? (r_gain_r + r_prod_r[63:32]) : (r_gain_r - r_prod_r[63:32]);
        if (g_l < i_cfg.gain_floor) begin
            g_l = i_cfg.gain_floor;
        end
        if (g_r < i_cfg.gain_floor) begin
            g_r = i_cfg.gain_floor;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_max_l  = r_max_l;
        n_max_r  = r_max_r;
        n_hold_l = r_hold_l;
        n_hold_r = r_hold_r;
        n_raw_l  = r_raw_l;
        n_raw_r  = r_raw_r;
        n_f_l    = r_f_l;
        n_f_r    = r_f_r;
        n_up_l   = r_up_l;
        n_up_r   = r_up_r;
        n_prod_l = r_prod_l;
        n_prod_r = r_prod_r;
        n_gain_l = r_gain_l;
        n_gain_r = r_gain_r;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        sq_start = 1'b0;
        o_done   = 1'b0;
        unique case (r_state)
            RO_IDLE: begin
                if (i_ctrl.start) begin
                    n_addr  = '0;
                    n_max_l = '0;
                    n_max_r = '0;
                    n_state = RO_READ;
                end
            end
            RO_READ: begin
                n_state = RO_DATA;
            end
            RO_DATA: begin
                if (r_addr == BW'(BANKS - 1)) begin
                    n_max_l  = (i_pow_l > r_max_l) ? i_pow_l : r_max_l;
                    n_max_r  = (i_pow_r > r_max_r) ? i_pow_r : r_max_r;
                    n_hold_l = i_pow_l;
                    n_hold_r = i_pow_r;
                    n_state  = RO_ROOT_GO;
                end else if (out_free) begin
                    n_max_l  = (i_pow_l > r_max_l) ? i_pow_l : r_max_l;
                    n_max_r  = (i_pow_r > r_max_r) ? i_pow_r : r_max_r;
                    n_ovalid = 1'b1;
                    n_out    = '0;
                    n_out.bank_number = 6'(r_addr);
                    n_out.power_left  = i_pow_l;
                    n_out.power_right = i_pow_r;
                    n_addr  = r_addr + BW'(1);
                    n_state = RO_READ;
                end
            end
            RO_ROOT_GO: begin
                sq_start = 1'b1;
                n_state  = RO_ROOT;
            end
            RO_ROOT: begin
                if (done_l && done_r) begin
                    n_raw_l = root_l;
                    n_raw_r = root_r;
                    n_state = RO_GAIN_F;
                end
            end
            RO_GAIN_F: begin
                n_up_l  = r_raw_l >= r_gain_l;
                n_up_r  = r_raw_r >= r_gain_r;
                n_f_l   = i_ctrl.count * ((r_raw_l < r_gain_l) ? i_cfg.dec_rate
                                                                : i_cfg.inc_rate);
                n_f_r   = i_ctrl.count * ((r_raw_r < r_gain_r) ? i_cfg.dec_rate
                                                                : i_cfg.inc_rate);
                n_state = RO_GAIN_P;
            end
            RO_GAIN_P: begin
                n_prod_l = diff_l * fs_l;
                n_prod_r = diff_r * fs_r;
                n_state  = RO_GAIN_A;
            end
            RO_GAIN_A: begin
                if (out_free) begin
                    n_gain_l = g_l;
                    n_gain_r = g_r;
                    n_ovalid = 1'b1;
                    n_out.bank_number    = 6'(BANKS - 1);
                    n_out.power_left     = r_hold_l;
                    n_out.power_right    = r_hold_r;
                    n_out.gain_left_out  = g_l;
                    n_out.gain_right_out = g_r;
                    n_out.peak_left  = (r_raw_l < i_cfg.gain_floor) ? i_cfg.gain_floor
                                                                    : r_raw_l;
                    n_out.peak_right = (r_raw_r < i_cfg.gain_floor) ? i_cfg.gain_floor
                                                                    : r_raw_r;
                    n_out.last       = 1'b1;
                    o_done  = 1'b1;
                    n_state = RO_IDLE;
                end
            end
            default: begin
                n_state = RO_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= RO_IDLE;
            r_ovalid <= 1'b0;
            r_gain_l <= GAIN_FLOOR_RESET;
            r_gain_r <= GAIN_FLOOR_RESET;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_gain_l <= n_gain_l;
            r_gain_r <= n_gain_r;
            r_addr   <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_l  <= n_max_l;
        r_max_r  <= n_max_r;
        r_hold_l <= n_hold_l;
        r_hold_r <= n_hold_r;
        r_raw_l  <= n_raw_l;
        r_raw_r  <= n_raw_r;
        r_f_l    <= n_f_l;
        r_f_r    <= n_f_r;
        r_up_l   <= n_up_l;
        r_up_r   <= n_up_r;
        r_prod_l <= n_prod_l;
        r_prod_r <= n_prod_r;
        r_out    <= n_out;
    end

    assign o_addr      = r_addr;
    assign o_out_valid = r_ovalid;
    assign o_out_res   = r_out;

endmodule

[design/stereo_bandpass_bank_power_agc_unit.sv]
// Top level of the stereo bandpass bank power meter with automatic gain.
// Instantiates two sbpa_lane channels and sbpa_merge. Depends on sbpa_pkg.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_stall   i_in_req (t_request)
//   result    out        o_out_valid / i_out_stall o_out_res (t_result)
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A stereo sample enters one bank into the two channel pipelines per cycle, after which the
// channel pipelines drain. A readout reads the powers of each bank in turn and then runs
// the 32-step square root and the gain update; it lasts longer while the result side stalls.
// Reset is synchronous and active low; the histories and powers read as zero after reset.
// Requests are stalled while a sample or a readout is in progress.
module stereo_bandpass_bank_power_agc_unit
    import sbpa_pkg::*;
#(
    parameter int BANKS = DEF_BANKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_request    i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;

    t_state r_state, n_state;

    t_coef r_coef_mem [BANKS];
    t_coef r_coef_rd;

    logic [BW-1:0]      r_bank, n_bank;
    logic [15:0]        r_count, n_count;
    logic signed [23:0] r_xl, n_xl, r_xr, n_xr;
    t_cfg               r_cfg;

    logic          accept;
    logic          issue;
    logic          ro_start;
    logic          coef_we;
    logic          busy_l, busy_r;
    logic [31:0]   pow_l, pow_r;
    logic [BW-1:0] ro_addr;
    logic          ro_done;
    t_ro_ctrl      ro_ctrl;
    t_coef         coef_wr;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign coef_wr.fb1    = i_in_req.coef_fb1;
    assign coef_wr.fb2    = i_in_req.coef_fb2;
    assign coef_wr.gain   = i_in_req.coef_gain;
    assign coef_wr.smooth = i_in_req.coef_smooth;

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_count  = r_count;
        n_xl     = r_xl;
        n_xr     = r_xr;
        issue    = 1'b0;
        ro_start = 1'b0;
        coef_we  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_opcode'(i_in_req.opcode))
                        OP_LOAD: begin
                            coef_we = ({1'b0, i_in_req.bank_index} < 7'(BANKS));
                        end
                        OP_SAMPLE: begin
                            n_xl    = i_in_req.sample_left;
                            n_xr    = i_in_req.sample_right;
                            n_bank  = '0;
                            n_count = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
                            n_state = ST_SAMPLE;
                        end
                        OP_READOUT: begin
                            ro_start = 1'b1;
                            n_state  = ST_READOUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SAMPLE: begin
                issue = 1'b1;
                if (r_bank == BW'(BANKS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_bank = r_bank + BW'(1);
                end
            end
            ST_DRAIN: begin
                if (!busy_l && !busy_r) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READOUT: begin
                if (ro_done) begin
                    n_count = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bank  <= '0;
            r_count <= '0;
            r_cfg   <= '{gain_floor: GAIN_FLOOR_RESET, inc_rate: INC_RATE_RESET,
                         dec_rate: DEC_RATE_RESET};
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_FLOOR: r_cfg.gain_floor <= i_cfg_data;
                    CFG_INC_RATE:   r_cfg.inc_rate   <= i_cfg_data;
                    CFG_DEC_RATE:   r_cfg.dec_rate   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xl <= n_xl;
        r_xr <= n_xr;
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[i_in_req.bank_index[BW-1:0]] <= coef_wr;
        end
        r_coef_rd <= r_coef_mem[r_bank];
    end

    sbpa_lane #(
        .BANKS (BANKS),
        .BW    (BW)
    ) u_lane_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_bank    (r_bank),
        .i_x       (r_xl),
        .i_coef    (r_coef_rd),
        .i_ro_addr (ro_addr),
        .o_power   (pow_l),
        .o_busy    (busy_l)
    );

    sbpa_lane #(
        .BANKS (BANKS),
        .BW    (BW)
    ) u_lane_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_bank    (r_bank),
        .i_x       (r_xr),
        .i_coef    (r_coef_rd),
        .i_ro_addr (ro_addr),
        .o_power   (pow_r),
        .o_busy    (busy_r)
    );

    assign ro_ctrl.start = ro_start;
    assign ro_ctrl.count = r_count;

    sbpa_merge #(
        .BANKS (BANKS),
        .BW    (BW)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ro_ctrl),
        .i_cfg       (r_cfg),
        .i_pow_l     (pow_l),
        .i_pow_r     (pow_r),
        .o_addr      (ro_addr),
        .o_done      (ro_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

`ifndef SYNTHESIS
    a_idle_lanes_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!busy_l && !busy_r))
        else $error("Channel pipelines still busy while idle.");

    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_DRAIN || r_state == ST_IDLE))
        else $error("Drain left for a state other than idle.");

    a_result_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (r_state == ST_READOUT || $past(r_state) == ST_READOUT))
        else $error("Result appeared outside a readout.");

    a_no_issue_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_state == ST_SAMPLE && !ro_done))
        else $error("Bank issued outside a sample pass.");
`endif

endmodule
